### rtl/assert_macros.svh
// Concurrent assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check under reset gating.
`define ASSERT_GATED(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/rme_pkg.sv
`timescale 1ns / 1ps

package rme_pkg;

    localparam int CFG_ADDR_W = 1;

    localparam logic [CFG_ADDR_W-1:0] REG_EXPONENT = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_MODULUS  = 1'b1;

    typedef enum logic [1:0] {
        MUL_REDUCE = 2'd0,
        MUL_ACC    = 2'd1,
        MUL_SQUARE = 2'd2
    } t_mul_op;

    typedef struct packed {
        logic    load;
        logic    mul_start;
        t_mul_op mul_op;
        logic    step;
        logic    acc_wr;
        logic    sq_wr;
        logic    exp_shift;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic last_step;
        logic exp_zero;
        logic exp_bit0;
    } t_dp_sts;

endpackage

### rtl/rme_datapath.sv
`timescale 1ns / 1ps

module rme_datapath #(
    parameter int WORD_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rme_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [WORD_BITS-1:0]            i_cfg_wdata,
    input  logic [WORD_BITS-1:0]            i_base,
    input  logic                            i_last,
    input  rme_pkg::t_dp_cmd                i_cmd,
    output rme_pkg::t_dp_sts                o_sts,
    output logic [WORD_BITS-1:0]            o_result,
    output logic                            o_last
);

    localparam int CNT_W = $clog2(WORD_BITS);
    localparam int SUM_W = WORD_BITS + 2;

    logic [WORD_BITS-1:0] r_cfg_exp;
    logic [WORD_BITS-1:0] r_cfg_mod;

    logic [WORD_BITS-1:0] r_acc;
    logic [WORD_BITS-1:0] r_sq;
    logic [WORD_BITS-1:0] r_exp;
    logic                 r_last;

    logic [WORD_BITS-1:0] r_mm;
    logic [WORD_BITS-1:0] r_mx;
    logic [WORD_BITS-1:0] r_my;
    logic [CNT_W-1:0]     r_cnt;

    logic [WORD_BITS-1:0] r_out_data;
    logic                 r_out_last;

    logic [WORD_BITS-1:0] n_mm;
    logic [WORD_BITS-1:0] w_start_x;
    logic [WORD_BITS-1:0] w_start_y;
    logic [WORD_BITS-1:0] w_addend;
    logic [SUM_W-1:0]     w_sum;
    logic [SUM_W-1:0]     w_n1;
    logic [SUM_W-1:0]     w_n2;
    logic                 w_mod_small;

    assign w_mod_small = (r_cfg_mod[WORD_BITS-1:1] == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_exp <= WORD_BITS'(1);
            r_cfg_mod <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                rme_pkg::REG_EXPONENT: r_cfg_exp <= i_cfg_wdata;
                rme_pkg::REG_MODULUS:  r_cfg_mod <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (i_cmd.mul_op)
            rme_pkg::MUL_REDUCE: begin
                w_start_x = WORD_BITS'(1);
                w_start_y = i_base;
            end
            rme_pkg::MUL_ACC: begin
                w_start_x = r_acc;
                w_start_y = r_sq;
            end
            rme_pkg::MUL_SQUARE: begin
                w_start_x = r_sq;
                w_start_y = r_sq;
            end
            default: begin
                w_start_x = '0;
                w_start_y = '0;
            end
        endcase
    end

    // 2r + bit*x stays below 3n: one of two subtractions brings it back under n.
    assign w_addend = r_my[WORD_BITS-1] ? r_mx : {WORD_BITS{1'b0}};
    assign w_sum    = {1'b0, r_mm, 1'b0} + {2'b00, w_addend};
    assign w_n1     = {2'b00, r_cfg_mod};
    assign w_n2     = {1'b0, r_cfg_mod, 1'b0};

    always_comb begin
        if (w_sum >= w_n2) begin
            n_mm = WORD_BITS'(w_sum - w_n2);
        end else if (w_sum >= w_n1) begin
            n_mm = WORD_BITS'(w_sum - w_n1);
        end else begin
            n_mm = w_sum[WORD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            r_mm  <= '0;
            r_mx  <= w_start_x;
            r_my  <= w_start_y;
            r_cnt <= '0;
        end else if (i_cmd.step) begin
            r_mm  <= n_mm;
            r_my  <= {r_my[WORD_BITS-2:0], 1'b0};
            r_cnt <= r_cnt + CNT_W'(1);
        end

        if (i_cmd.load) begin
            r_acc  <= w_mod_small ? '0 : WORD_BITS'(1);
            r_exp  <= w_mod_small ? '0 : r_cfg_exp;
            r_last <= i_last;
        end else begin
            if (i_cmd.acc_wr) begin
                r_acc <= n_mm;
            end
            if (i_cmd.exp_shift) begin
                r_exp <= {1'b0, r_exp[WORD_BITS-1:1]};
            end
        end

        if (i_cmd.sq_wr) begin
            r_sq <= n_mm;
        end

        if (i_cmd.out_load) begin
            r_out_data <= r_acc;
            r_out_last <= r_last;
        end
    end

    assign o_sts.last_step = (r_cnt == CNT_W'(WORD_BITS - 1));
    assign o_sts.exp_zero  = (r_exp == '0);
    assign o_sts.exp_bit0  = r_exp[0];

    assign o_result = r_out_data;
    assign o_last   = r_out_last;

endmodule

### rtl/rme_ctrl.sv
`timescale 1ns / 1ps

module rme_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rme_pkg::t_dp_cmd  o_cmd,
    input  rme_pkg::t_dp_sts  i_sts
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RED  = 6'b000010,
        S_NEXT = 6'b000100,
        S_MACC = 6'b001000,
        S_SQR  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load      = 1'b1;
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_op    = rme_pkg::MUL_REDUCE;
                    n_state         = S_RED;
                end
            end
            S_RED: begin
                o_cmd.step = 1'b1;
                if (i_sts.last_step) begin
                    o_cmd.sq_wr = 1'b1;
                    n_state     = S_NEXT;
                end
            end
            S_NEXT: begin
                if (i_sts.exp_zero) begin
                    n_state = S_DONE;
                end else if (i_sts.exp_bit0) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_op    = rme_pkg::MUL_ACC;
                    n_state         = S_MACC;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_op    = rme_pkg::MUL_SQUARE;
                    n_state         = S_SQR;
                end
            end
            S_MACC: begin
                o_cmd.step = 1'b1;
                if (i_sts.last_step) begin
                    o_cmd.acc_wr    = 1'b1;
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_op    = rme_pkg::MUL_SQUARE;
                    n_state         = S_SQR;
                end
            end
            S_SQR: begin
                o_cmd.step = 1'b1;
                if (i_sts.last_step) begin
                    o_cmd.sq_wr     = 1'b1;
                    o_cmd.exp_shift = 1'b1;
                    n_state         = S_NEXT;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### rtl/rsa_modular_exponentiation_unit.sv
`timescale 1ns / 1ps
// Channel   Dir  Signals                        Beat content
// --------  ---  -----------------------------  ---------------------------------
// s_axis    in   tvalid tready tdata tlast      base, last_element
// m_axis    out  tvalid tready tdata tlast      power_result, last_result
// cfg       in   i_cfg_we i_cfg_addr i_cfg_wdata 0: exponent, 1: modulus
//
// The base is first reduced modulo the modulus; then, from the lowest exponent bit,
// a set bit multiplies the result by the running square and every bit squares it,
// until no set exponent bit is left.
// One bit-serial modular multiplier, one multiplier bit per cycle, does it all.
// Reset is synchronous, active low; exponent returns to 1, modulus to all ones.
// A finished result waits in the output register; the next beat is taken
// meanwhile, and the engine stalls only when a second result is ready.

module rsa_modular_exponentiation_unit #(
    parameter int WORD_BITS = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [((WORD_BITS + 7) / 8) * 8-1:0] s_axis_tdata,  // [WORD_BITS-1:0] base
    input  logic                                 s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [((WORD_BITS + 7) / 8) * 8-1:0] m_axis_tdata,  // [WORD_BITS-1:0] power_result
    output logic                                 m_axis_tlast,
    input  logic                                 i_cfg_we,
    input  logic [rme_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [WORD_BITS-1:0]                 i_cfg_wdata
);

    localparam int DATA_W = ((WORD_BITS + 7) / 8) * 8;

    rme_pkg::t_dp_cmd     w_cmd;
    rme_pkg::t_dp_sts     w_sts;
    logic [WORD_BITS-1:0] w_result;

    rme_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    rme_datapath #(
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_base      (s_axis_tdata[WORD_BITS-1:0]),
        .i_last      (s_axis_tlast),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_result    (w_result),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = DATA_W'(w_result);

endmodule

### rtl/rme_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rme_checker #(
    parameter int WORD_BITS = 32
) (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 s_axis_tvalid,
    input logic                                 s_axis_tready,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [((WORD_BITS + 7) / 8) * 8-1:0] m_axis_tdata,
    input logic                                 m_axis_tlast
);

    `ASSERT_GATED(a_out_hold, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
        "result beat changed while stalled")

    `ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !m_axis_tvalid,
        "result valid right after reset")

    `ASSERT_GATED(a_busy_after_accept, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready,
        "input taken again before the engine finished")

    `ASSERT_GATED(a_result_from_busy, i_clk, i_rst_n,
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready),
        "result appeared while the engine sat idle")

endmodule

bind rsa_modular_exponentiation_unit rme_checker #(
    .WORD_BITS (WORD_BITS)
) u_rme_checker (.*);
